### hw/rtl/quaternion_multiply_normalize_unit_macros.svh
// Assertion macros for the quaternion multiply/normalize unit.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_UNIT_MACROS_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define QMN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define QMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qmn_pkg.sv
// Shared widths and types for the quaternion multiply/normalize unit.
package qmn_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = 2 * COMP_WIDTH;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NQ_W       = 31;
  localparam int LEN_W      = $clog2(SUM_W + 1);
  localparam int SHW_W      = SUM_W + NQ_W;
  localparam int NSQ_W      = 2 * NQ_W;
  localparam int N_W        = 2 * NQ_W + 2;
  localparam int S_W        = N_W / 2;
  localparam int REM_W      = S_W + 3;
  localparam int QUOT_W     = COMP_WIDTH;
  localparam int DIV_W      = S_W + QUOT_W;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [NQ_W-1:0] mag_t;

  // Payload that rides beside the square root.
  typedef struct packed {
    logic            zero;
    logic [3:0]      neg;
    logic [3:0][NQ_W-1:0] q;
  } side_t;

endpackage

### hw/rtl/qmn_product.sv
// Hamilton product: multiplies, four-term sums, then sign and magnitude.
module qmn_product (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  qmn_pkg::comp_t               a_x_i,
  input  qmn_pkg::comp_t               a_y_i,
  input  qmn_pkg::comp_t               a_z_i,
  input  qmn_pkg::comp_t               a_w_i,
  input  qmn_pkg::comp_t               b_x_i,
  input  qmn_pkg::comp_t               b_y_i,
  input  qmn_pkg::comp_t               b_z_i,
  input  qmn_pkg::comp_t               b_w_i,
  output logic                         valid_o,
  output logic [3:0]                   neg_o,
  output logic [3:0][qmn_pkg::SUM_W-1:0] mag_o
);
  import qmn_pkg::*;

  logic signed [PROD_W-1:0] pr_q [16];
  logic signed [SUM_W-1:0]  sum_d [4];
  logic signed [SUM_W-1:0]  sum_q [4];
  logic [3:0]               neg_q;
  logic [3:0][SUM_W-1:0]    mag_q;
  logic [2:0]               vld_q;

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] v);
    return SUM_W'(v);
  endfunction

  // product order per output row: three added terms, fourth subtracted (w row: 1 - 3)
  always_ff @(posedge clk_i) begin
    pr_q[0]  <= a_w_i * b_x_i;
    pr_q[1]  <= a_x_i * b_w_i;
    pr_q[2]  <= a_y_i * b_z_i;
    pr_q[3]  <= a_z_i * b_y_i;
    pr_q[4]  <= a_w_i * b_y_i;
    pr_q[5]  <= a_y_i * b_w_i;
    pr_q[6]  <= a_z_i * b_x_i;
    pr_q[7]  <= a_x_i * b_z_i;
    pr_q[8]  <= a_w_i * b_z_i;
    pr_q[9]  <= a_z_i * b_w_i;
    pr_q[10] <= a_x_i * b_y_i;
    pr_q[11] <= a_y_i * b_x_i;
    pr_q[12] <= a_w_i * b_w_i;
    pr_q[13] <= a_x_i * b_x_i;
    pr_q[14] <= a_y_i * b_y_i;
    pr_q[15] <= a_z_i * b_z_i;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = ext(pr_q[4*i]) + ext(pr_q[4*i+1]) + ext(pr_q[4*i+2]) - ext(pr_q[4*i+3]);
    end
    sum_d[3] = ext(pr_q[12]) - ext(pr_q[13]) - ext(pr_q[14]) - ext(pr_q[15]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      sum_q[i] <= sum_d[i];
      neg_q[i] <= sum_q[i][SUM_W-1];
      mag_q[i] <= sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : SUM_W'(sum_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign neg_o   = neg_q;
  assign mag_o   = mag_q;
endmodule

### hw/rtl/qmn_norm.sv
// Block scaling to a 31-bit top magnitude, then sum of squares.
module qmn_norm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [3:0]                     neg_i,
  input  logic [3:0][qmn_pkg::SUM_W-1:0] mag_i,
  output logic                           valid_o,
  output logic [qmn_pkg::N_W-1:0]        n_o,
  output qmn_pkg::side_t                 side_o
);
  import qmn_pkg::*;

  logic [SUM_W-1:0]      all_or;
  logic [LEN_W-1:0]      len_d, len_q;
  logic [3:0][SUM_W-1:0] mag1_q;
  logic [3:0]            neg1_q, neg2_q, neg3_q, neg4_q;
  logic [3:0][NQ_W-1:0]  q2_q, q3_q, q4_q;
  logic                  z2_q, z3_q, z4_q;
  logic [NSQ_W-1:0]      sq_q [4];
  logic [N_W-1:0]        n_q;
  logic [3:0]            vld_q;

  always_comb begin
    all_or = mag_i[0] | mag_i[1] | mag_i[2] | mag_i[3];
    len_d  = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (all_or[i]) len_d = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    mag1_q <= mag_i;
    neg1_q <= neg_i;
    // mag * 2^(NQ_W - len): right shifts truncate
    for (int i = 0; i < 4; i++) begin
      q2_q[i] <= NQ_W'({mag1_q[i], {NQ_W{1'b0}}} >> len_q);
      sq_q[i] <= q2_q[i] * q2_q[i];
    end
    z2_q   <= (len_q == '0);
    neg2_q <= neg1_q;
    q3_q   <= q2_q;
    z3_q   <= z2_q;
    neg3_q <= neg2_q;
    n_q    <= N_W'(sq_q[0]) + N_W'(sq_q[1]) + N_W'(sq_q[2]) + N_W'(sq_q[3]);
    q4_q   <= q3_q;
    z4_q   <= z3_q;
    neg4_q <= neg3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o     = vld_q[3];
  assign n_o         = n_q;
  assign side_o.zero = z4_q;
  assign side_o.neg  = neg4_q;
  assign side_o.q    = q4_q;
endmodule

### hw/rtl/qmn_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module qmn_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [qmn_pkg::N_W-1:0] n_i,
  input  qmn_pkg::side_t          side_i,
  output logic                    valid_o,
  output logic [qmn_pkg::S_W-1:0] root_o,
  output qmn_pkg::side_t          side_o
);
  import qmn_pkg::*;

  logic [REM_W-1:0] rem_q  [S_W];
  logic [S_W-1:0]   root_q [S_W];
  logic [N_W-1:0]   nb_q   [S_W];
  side_t            side_q [S_W];
  logic [S_W-1:0]   vld_q;

  for (genvar k = 0; k < S_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_p, remx, trial;
    logic [S_W-1:0]   root_p;
    logic [N_W-1:0]   nb_p;
    side_t            side_p;
    logic             vld_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign nb_p   = n_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign nb_p   = nb_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign remx  = {rem_p[REM_W-3:0], nb_p[N_W-1:N_W-2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? (remx - trial) : remx;
      root_q[k] <= {root_p[S_W-2:0], ge};
      nb_q[k]   <= {nb_p[N_W-3:0], 2'b00};
      side_q[k] <= side_p;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[S_W-1];
  assign root_o  = root_q[S_W-1];
  assign side_o  = side_q[S_W-1];
endmodule

### hw/rtl/qmn_div.sv
// Four-lane rounded division q * 2^FRAC_BITS / s, one quotient bit per stage.
module qmn_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [qmn_pkg::S_W-1:0]          s_i,
  input  qmn_pkg::side_t                   side_i,
  output logic                             valid_o,
  output logic                             zero_o,
  output logic [3:0]                       neg_o,
  output logic [3:0][qmn_pkg::QUOT_W-1:0]  quot_o
);
  import qmn_pkg::*;

  logic [3:0][DIV_W-1:0]  rem_q  [QUOT_W+1];
  logic [3:0][QUOT_W-1:0] quot_q [QUOT_W+1];
  logic [S_W-1:0]         s_q    [QUOT_W+1];
  logic                   zero_q [QUOT_W+1];
  logic [3:0]             neg_q  [QUOT_W+1];
  logic [QUOT_W:0]        vld_q;

  // numerator with half the divisor added for round-to-nearest
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      rem_q[0][i] <= DIV_W'({side_i.q[i], {FRAC_BITS{1'b0}}}) + DIV_W'(s_i >> 1);
    end
    quot_q[0] <= '0;
    s_q[0]    <= s_i;
    zero_q[0] <= side_i.zero;
    neg_q[0]  <= side_i.neg;
  end

  for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
    logic [DIV_W-1:0] dsh;
    assign dsh = DIV_W'(s_q[k-1]) << (QUOT_W - k);

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 4; i++) begin
        if (rem_q[k-1][i] >= dsh) begin
          rem_q[k][i]  <= rem_q[k-1][i] - dsh;
          quot_q[k][i] <= {quot_q[k-1][i][QUOT_W-2:0], 1'b1};
        end else begin
          rem_q[k][i]  <= rem_q[k-1][i];
          quot_q[k][i] <= {quot_q[k-1][i][QUOT_W-2:0], 1'b0};
        end
      end
      s_q[k]    <= s_q[k-1];
      zero_q[k] <= zero_q[k-1];
      neg_q[k]  <= neg_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QUOT_W-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[QUOT_W];
  assign zero_o  = zero_q[QUOT_W];
  assign neg_o   = neg_q[QUOT_W];
  assign quot_o  = quot_q[QUOT_W];
endmodule

### hw/rtl/quaternion_multiply_normalize_unit.sv
// Top level: normalized Hamilton product of two Q2.14 quaternions.
//
// Usage: drive a_*_i and b_*_i and raise start for one cycle per item.
// busy is held low: an item can be started in every cycle, back to back.
// Each item gives one result on r_*_o / zero_norm_o, shown for exactly one
// cycle while done_o is high; done_o rises once the item has passed all 57
// register stages, the first of which is loaded by the edge that took start.
// Throughput is one item per cycle; the stages are the 32-stage square
// root (one root bit per stage) and the 17-stage divider (setup plus one
// quotient bit per stage), plus 3 product, 4 scaling and 1 output stage.
// Results leave in start order. The receiver cannot stall, so nothing is
// held back. zero_norm_o flags a zero product; r_*_o are then zero.
// Reset (rst_ni low, asynchronous) clears all in-flight valid bits; items
// in the pipe at reset are dropped and no done_o follows them.
// No configuration, no state between items.
module quaternion_multiply_normalize_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  qmn_pkg::comp_t a_x_i,
  input  qmn_pkg::comp_t a_y_i,
  input  qmn_pkg::comp_t a_z_i,
  input  qmn_pkg::comp_t a_w_i,
  input  qmn_pkg::comp_t b_x_i,
  input  qmn_pkg::comp_t b_y_i,
  input  qmn_pkg::comp_t b_z_i,
  input  qmn_pkg::comp_t b_w_i,
  output logic           done_o,
  output qmn_pkg::comp_t r_x_o,
  output qmn_pkg::comp_t r_y_o,
  output qmn_pkg::comp_t r_z_o,
  output qmn_pkg::comp_t r_w_o,
  output logic           zero_norm_o
);
  import qmn_pkg::*;
  `include "quaternion_multiply_normalize_unit_macros.svh"

  logic                  pv, nv, sv, dv, dzero;
  logic [3:0]            pneg, dneg;
  logic [3:0][SUM_W-1:0] pmag;
  logic [N_W-1:0]        nsum;
  side_t                 nside, sside;
  logic [S_W-1:0]        root;
  logic [3:0][QUOT_W-1:0] quot;
  comp_t                 r_d [4];
  comp_t                 r_q [4];
  logic                  done_q, zero_q;

  assign busy = 1'b0;

  qmn_product u_product (
    .clk_i, .rst_ni, .valid_i(start && !busy),
    .a_x_i, .a_y_i, .a_z_i, .a_w_i, .b_x_i, .b_y_i, .b_z_i, .b_w_i,
    .valid_o(pv), .neg_o(pneg), .mag_o(pmag)
  );

  qmn_norm u_norm (
    .clk_i, .rst_ni, .valid_i(pv), .neg_i(pneg), .mag_i(pmag),
    .valid_o(nv), .n_o(nsum), .side_o(nside)
  );

  qmn_sqrt u_sqrt (
    .clk_i, .rst_ni, .valid_i(nv), .n_i(nsum), .side_i(nside),
    .valid_o(sv), .root_o(root), .side_o(sside)
  );

  qmn_div u_div (
    .clk_i, .rst_ni, .valid_i(sv), .s_i(root), .side_i(sside),
    .valid_o(dv), .zero_o(dzero), .neg_o(dneg), .quot_o(quot)
  );

  // saturate, apply sign, force zero on a zero product
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [QUOT_W-1:0] mag;
      mag = quot[i][QUOT_W-1] ? {1'b0, {(QUOT_W-1){1'b1}}} : quot[i];
      if (dzero) begin
        r_d[i] = '0;
      end else if (dneg[i]) begin
        r_d[i] = comp_t'(-mag);
      end else begin
        r_d[i] = comp_t'(mag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    zero_q <= dzero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv;
    end
  end

  assign done_o      = done_q;
  assign zero_norm_o = zero_q;
  assign r_x_o       = r_q[0];
  assign r_y_o       = r_q[1];
  assign r_z_o       = r_q[2];
  assign r_w_o       = r_q[3];

  `QMN_ASSERT_NOW(a_zero_out, done_o && zero_norm_o, (r_x_o == '0) && (r_y_o == '0) && (r_z_o == '0) && (r_w_o == '0), "zero product with nonzero components")
  `QMN_ASSERT_NOW(a_unit_nonzero, done_o && !zero_norm_o, (r_x_o != '0) || (r_y_o != '0) || (r_z_o != '0) || (r_w_o != '0), "normalized product is all zero")
  `QMN_ASSERT_NEXT(a_div_to_done, dv, done_o, "divider result not strobed out")
endmodule
